/* hdl/bba_pkg.sv */
// shared constants and codes of the buddy block allocator
`default_nettype none
package bba_pkg;
    localparam int ORDERS_DEF = 16;

    localparam int OP_W   = 2;
    localparam int REQ_W  = 16;
    localparam int ROFF_W = 15;
    localparam int BOFF_W = 15;
    localparam int BORD_W = 4;
    localparam int STAT_W = 2;
    localparam int POOL_W = 16;

    localparam logic [POOL_W-1:0] POOL_RESET = 16'd32768;

    localparam logic [OP_W-1:0] OP_INIT    = 2'd0;
    localparam logic [OP_W-1:0] OP_ALLOC   = 2'd1;
    localparam logic [OP_W-1:0] OP_RELEASE = 2'd2;

    localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STAT_W-1:0] STAT_NO_FREE   = 2'd1;
    localparam logic [STAT_W-1:0] STAT_TOO_LARGE = 2'd2;
    localparam logic [STAT_W-1:0] STAT_NOT_ALLOC = 2'd3;
endpackage
`default_nettype wire

/* hdl/bba_req_if.sv */
// request channel: operation and its arguments
`default_nettype none
interface bba_req_if;
    logic                        valid;
    logic                        ready;
    logic [bba_pkg::OP_W-1:0]    operation;
    logic [bba_pkg::REQ_W-1:0]   request_units;
    logic [bba_pkg::ROFF_W-1:0]  release_offset;

    modport source (output valid, operation, request_units, release_offset, input ready);
    modport sink (input valid, operation, request_units, release_offset, output ready);
endinterface
`default_nettype wire

/* hdl/bba_rsp_if.sv */
// response channel: block offset, order and status
`default_nettype none
interface bba_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [bba_pkg::BOFF_W-1:0]  block_offset;
    logic [bba_pkg::BORD_W-1:0]  block_order;
    logic [bba_pkg::STAT_W-1:0]  status;

    modport source (output valid, block_offset, block_order, status, input ready);
    modport sink (input valid, block_offset, block_order, status, output ready);
endinterface
`default_nettype wire

/* hdl/buddy_block_allocator_unit.sv */
// buddy allocator: free-mark and allocated-order memories with a sequencer
// Free marks live in one memory of FW-bit words (one bit per order and aligned block),
// the order of each allocated block in a second memory indexed by unit offset; both have
// registered reads, and the marks are updated read-modify-write, one access at a time, so
// no two accesses to one word overlap. A free count per order picks the order to search.
// After reset a clearing pass over both memories runs before the first item is taken
// (configuration writes are taken throughout). Per item: init clears both memories and
// marks free the largest aligned blocks that fit in the pool, top order down; allocate
// scans the mark words of the chosen order (at worst 2^(ORDERS-1)/FW words at order 0),
// takes the first free mark and splits down to the requested order, or fails without a
// search; release reads the stored order, merges with each free buddy up the orders and
// sets the final mark, or reports it not allocated; an ignored operation is dropped. The
// handoff waits while the output register holds an untaken result. One item is in work
// at a time; a finished result waits there while the next item is taken.
`default_nettype none
module buddy_block_allocator_unit #(
    parameter int ORDERS = bba_pkg::ORDERS_DEF
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_cfg_valid,
    input  wire [bba_pkg::POOL_W-1:0]   i_cfg_data,
    output logic                        o_cfg_ready,
    bba_req_if.sink                     i_req,
    bba_rsp_if.source                   o_rsp
);
    localparam int OW   = ORDERS - 1;
    localparam int MAX  = 1 << OW;
    localparam int MI   = ORDERS;
    localparam int FW   = (MAX < 32) ? MAX : 32;
    localparam int FWB  = $clog2(FW);
    localparam int NFW  = (2 * MAX) / FW;
    localparam int WAW  = MI - FWB;
    localparam int KW   = $clog2(ORDERS);
    localparam int AW   = $clog2(ORDERS + 1);
    localparam int CW   = ORDERS;
    localparam int SW   = (ORDERS > 16) ? ORDERS : 17;
    localparam int TOP  = ORDERS - 1;
    localparam logic [KW-1:0] TOP_K = KW'(TOP);
    localparam int REQ_MSB = bba_pkg::REQ_W - 1;

    localparam logic [3:0] S_CLR   = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_PLACE = 4'd2;
    localparam logic [3:0] S_PNEXT = 4'd3;
    localparam logic [3:0] S_BRD   = 4'd4;
    localparam logic [3:0] S_BWR   = 4'd5;
    localparam logic [3:0] S_SRD   = 4'd6;
    localparam logic [3:0] S_SCHK  = 4'd7;
    localparam logic [3:0] S_SPLIT = 4'd8;
    localparam logic [3:0] S_ARD   = 4'd9;
    localparam logic [3:0] S_ACHK  = 4'd10;
    localparam logic [3:0] S_MERGE = 4'd11;
    localparam logic [3:0] S_MRD   = 4'd12;
    localparam logic [3:0] S_MCHK  = 4'd13;
    localparam logic [3:0] S_DONE  = 4'd14;

    // mark index of aligned block at offset off in order k
    function automatic logic [MI-1:0] f_mark(input logic [KW-1:0] k, input logic [OW-1:0] off);
        logic [MI:0] base;
        base = (MI+1)'(2 * MAX) - ((MI+1)'(2 * MAX) >> k);
        f_mark = base[MI-1:0] + MI'(off >> k);
    endfunction

    function automatic logic [MI:0] f_lim(input logic [KW-1:0] k);
        f_lim = (MI+1)'(2 * MAX) - ((MI+1)'(MAX) >> k);
    endfunction

    function automatic logic [bba_pkg::BOFF_W-1:0] f_out_off(input logic [OW-1:0] v);
        logic [OW+bba_pkg::BOFF_W-1:0] t;
        t = {{bba_pkg::BOFF_W{1'b0}}, v};
        f_out_off = t[bba_pkg::BOFF_W-1:0];
    endfunction

    function automatic logic [bba_pkg::BORD_W-1:0] f_out_ord(input logic [KW-1:0] v);
        logic [KW+bba_pkg::BORD_W-1:0] t;
        t = {{bba_pkg::BORD_W{1'b0}}, v};
        f_out_ord = t[bba_pkg::BORD_W-1:0];
    endfunction

    logic [3:0]                  r_state, n_state, r_ret, n_ret;
    logic [OW-1:0]               r_clr, n_clr;
    logic                        r_initop, n_initop;
    logic [KW-1:0]               r_k, n_k, r_ord, n_ord;
    logic [OW-1:0]               r_off, n_off, r_cur, n_cur;
    logic [SW-1:0]               r_poff, n_poff;
    logic [MI-1:0]               r_fidx, n_fidx;
    logic                        r_fval, n_fval;
    logic [CW-1:0]               r_cnt [ORDERS];
    logic [bba_pkg::POOL_W-1:0]  r_pool;
    logic [bba_pkg::BOFF_W-1:0]  r_res_off, n_res_off, r_out_off;
    logic [bba_pkg::BORD_W-1:0]  r_res_ord, n_res_ord, r_out_ord;
    logic [bba_pkg::STAT_W-1:0]  r_res_st, n_res_st, r_out_st;
    logic                        r_out_valid;
    logic                        out_load;

    logic [FW-1:0]               r_fmem [NFW];
    logic [AW-1:0]               r_amem [MAX];
    logic [FW-1:0]               r_fdata;
    logic [AW-1:0]               r_adata;

    logic                        fwe, awe;
    logic [WAW-1:0]              fwaddr;
    logic [FW-1:0]               fwdata;
    logic [OW-1:0]               awaddr;
    logic [AW-1:0]               awdata;
    logic                        cnt_clr, cnt_inc, cnt_dec;
    logic [KW-1:0]               cnt_idx;

    // request decode
    logic [REQ_MSB:0]            rq1;
    logic [4:0]                  ord5;
    logic [KW+4:0]               ord_t;
    logic [KW-1:0]               ord_k;
    logic                        too_large;
    logic                        fk_found;
    logic [KW-1:0]               fk;
    logic [OW+bba_pkg::ROFF_W-1:0] roff_t;
    logic [OW-1:0]               roff_k;
    logic                        roff_oor;

    always_comb begin
        rq1 = (i_req.request_units == '0) ? '0 : i_req.request_units - 1'b1;
        ord5 = 5'd0;
        for (int i = 0; i < bba_pkg::REQ_W; i++) begin
            if (rq1[i]) begin
                ord5 = 5'(i + 1);
            end
        end
        too_large = ord5 > 5'(TOP);
        ord_t = {{KW{1'b0}}, ord5};
        ord_k = ord_t[KW-1:0];
        fk_found = 1'b0;
        fk = '0;
        for (int i = ORDERS - 1; i >= 0; i--) begin
            if (5'(i) >= ord5 && r_cnt[i] != '0) begin
                fk_found = 1'b1;
                fk = KW'(i);
            end
        end
        roff_t = {{OW{1'b0}}, i_req.release_offset};
        roff_k = roff_t[OW-1:0];
        roff_oor = (roff_t >> OW) != '0;
    end

    // scan of one mark word within the region of order r_k
    logic [WAW-1:0]              sw_w;
    logic [FW-1:0]               hit;
    logic [FWB-1:0]              hit_b;
    logic [MI-1:0]               hit_idx, blk, blk_sh, base_k;
    logic [MI:0]                 lim_k, cand;

    always_comb begin
        sw_w = r_fidx[MI-1:FWB];
        base_k = f_mark(r_k, '0);
        lim_k = f_lim(r_k);
        hit_b = '0;
        for (int b = 0; b < FW; b++) begin
            cand = {1'b0, sw_w, FWB'(b)};
            hit[b] = r_fdata[b] && cand >= {1'b0, base_k} && cand < lim_k;
        end
        for (int b = FW - 1; b >= 0; b--) begin
            if (hit[b]) begin
                hit_b = FWB'(b);
            end
        end
        hit_idx = {sw_w, hit_b};
        blk = hit_idx - base_k;
        blk_sh = blk << r_k;
    end

    logic [SW-1:0]               pool_sz, plen;
    logic [KW-1:0]               km1;
    logic [AW-1:0]               am1;
    logic [FW-1:0]               fmod;

    always_comb begin
        pool_sz = (SW'(r_pool) > SW'(MAX)) ? SW'(MAX) : SW'(r_pool);
        plen = SW'(1) << r_k;
        km1 = r_k - 1'b1;
        am1 = r_adata - 1'b1;
        fmod = r_fdata;
        fmod[r_fidx[FWB-1:0]] = r_fval;
    end

    always_comb begin
        n_state = r_state;
        n_ret = r_ret;
        n_clr = r_clr;
        n_initop = r_initop;
        n_k = r_k;
        n_ord = r_ord;
        n_off = r_off;
        n_cur = r_cur;
        n_poff = r_poff;
        n_fidx = r_fidx;
        n_fval = r_fval;
        n_res_off = r_res_off;
        n_res_ord = r_res_ord;
        n_res_st = r_res_st;
        fwe = 1'b0;
        fwaddr = r_fidx[MI-1:FWB];
        fwdata = fmod;
        awe = 1'b0;
        awaddr = r_off;
        awdata = '0;
        cnt_clr = 1'b0;
        cnt_inc = 1'b0;
        cnt_dec = 1'b0;
        cnt_idx = r_k;
        out_load = 1'b0;
        case (r_state)
            S_CLR: begin
                awe = 1'b1;
                awaddr = r_clr;
                if ((r_clr >> WAW) == '0) begin
                    fwe = 1'b1;
                    fwaddr = r_clr[WAW-1:0];
                    fwdata = '0;
                end
                n_clr = r_clr + 1'b1;
                if (r_clr == OW'(MAX - 1)) begin
                    if (r_initop) begin
                        n_k = TOP_K;
                        n_poff = '0;
                        n_state = S_PLACE;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_IDLE: begin
                if (i_req.valid) begin
                    case (i_req.operation)
                        bba_pkg::OP_INIT: begin
                            n_clr = '0;
                            n_initop = 1'b1;
                            cnt_clr = 1'b1;
                            n_state = S_CLR;
                        end
                        bba_pkg::OP_ALLOC: begin
                            if (too_large) begin
                                n_res_off = '0;
                                n_res_ord = '0;
                                n_res_st = bba_pkg::STAT_TOO_LARGE;
                                n_state = S_DONE;
                            end else if (!fk_found) begin
                                n_res_off = '0;
                                n_res_ord = ord5[bba_pkg::BORD_W-1:0];
                                n_res_st = bba_pkg::STAT_NO_FREE;
                                n_state = S_DONE;
                            end else begin
                                n_k = fk;
                                n_ord = ord_k;
                                n_fidx = f_mark(fk, '0);
                                n_state = S_SRD;
                            end
                        end
                        bba_pkg::OP_RELEASE: begin
                            n_res_off = i_req.release_offset;
                            n_res_ord = '0;
                            n_res_st = bba_pkg::STAT_NOT_ALLOC;
                            if (roff_oor) begin
                                n_state = S_DONE;
                            end else begin
                                n_off = roff_k;
                                n_state = S_ARD;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_PLACE: begin
                if (r_poff + plen <= pool_sz) begin
                    n_fidx = f_mark(r_k, r_poff[OW-1:0]);
                    n_fval = 1'b1;
                    cnt_inc = 1'b1;
                    n_poff = r_poff + plen;
                    n_ret = S_PNEXT;
                    n_state = S_BRD;
                end else begin
                    n_state = S_PNEXT;
                end
            end
            S_PNEXT: begin
                if (r_k == '0) begin
                    n_res_off = '0;
                    n_res_ord = '0;
                    n_res_st = bba_pkg::STAT_OK;
                    n_initop = 1'b0;
                    n_state = S_DONE;
                end else begin
                    n_k = km1;
                    n_state = S_PLACE;
                end
            end
            S_BRD: begin
                n_state = S_BWR;
            end
            S_BWR: begin
                fwe = 1'b1;
                n_state = r_ret;
            end
            S_SRD: begin
                n_state = S_SCHK;
            end
            S_SCHK: begin
                if (hit != '0) begin
                    n_off = blk_sh[OW-1:0];
                    n_fidx = hit_idx;
                    n_fval = 1'b0;
                    cnt_dec = 1'b1;
                    n_ret = S_SPLIT;
                    n_state = S_BWR;
                end else begin
                    n_fidx = {sw_w + 1'b1, {FWB{1'b0}}};
                    n_state = S_SRD;
                end
            end
            S_SPLIT: begin
                if (r_k > r_ord) begin
                    // free the upper half one order down
                    n_fidx = f_mark(km1, r_off | (OW'(1) << km1));
                    n_fval = 1'b1;
                    cnt_idx = km1;
                    cnt_inc = 1'b1;
                    n_k = km1;
                    n_ret = S_SPLIT;
                    n_state = S_BRD;
                end else begin
                    awe = 1'b1;
                    awdata = AW'(r_ord) + 1'b1;
                    n_res_off = f_out_off(r_off);
                    n_res_ord = f_out_ord(r_ord);
                    n_res_st = bba_pkg::STAT_OK;
                    n_state = S_DONE;
                end
            end
            S_ARD: begin
                n_state = S_ACHK;
            end
            S_ACHK: begin
                if (r_adata == '0) begin
                    n_state = S_DONE;
                end else begin
                    awe = 1'b1;
                    awdata = '0;
                    n_ord = am1[KW-1:0];
                    n_k = am1[KW-1:0];
                    n_cur = r_off;
                    n_res_ord = f_out_ord(am1[KW-1:0]);
                    n_res_st = bba_pkg::STAT_OK;
                    n_state = S_MERGE;
                end
            end
            S_MERGE: begin
                if (r_k < TOP_K) begin
                    n_fidx = f_mark(r_k, r_cur ^ (OW'(1) << r_k));
                    n_state = S_MRD;
                end else begin
                    n_fidx = f_mark(r_k, r_cur);
                    n_fval = 1'b1;
                    cnt_inc = 1'b1;
                    n_ret = S_DONE;
                    n_state = S_BRD;
                end
            end
            S_MRD: begin
                n_state = S_MCHK;
            end
            S_MCHK: begin
                if (r_fdata[r_fidx[FWB-1:0]]) begin
                    // buddy free: take it out and climb
                    n_fval = 1'b0;
                    cnt_dec = 1'b1;
                    n_cur = r_cur & ~(OW'(1) << r_k);
                    n_k = r_k + 1'b1;
                    n_ret = S_MERGE;
                    n_state = S_BWR;
                end else begin
                    n_fidx = f_mark(r_k, r_cur);
                    n_fval = 1'b1;
                    cnt_inc = 1'b1;
                    n_ret = S_DONE;
                    n_state = S_BRD;
                end
            end
            S_DONE: begin
                if (!r_out_valid || o_rsp.ready) begin
                    out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_ret <= S_IDLE;
            r_clr <= '0;
            r_initop <= 1'b0;
            r_pool <= bba_pkg::POOL_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ret <= n_ret;
            r_clr <= n_clr;
            r_initop <= n_initop;
            if (i_cfg_valid) begin
                r_pool <= i_cfg_data;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_k <= n_k;
        r_ord <= n_ord;
        r_off <= n_off;
        r_cur <= n_cur;
        r_poff <= n_poff;
        r_fidx <= n_fidx;
        r_fval <= n_fval;
        r_res_off <= n_res_off;
        r_res_ord <= n_res_ord;
        r_res_st <= n_res_st;
        if (out_load) begin
            r_out_off <= r_res_off;
            r_out_ord <= r_res_ord;
            r_out_st <= r_res_st;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || cnt_clr) begin
            for (int i = 0; i < ORDERS; i++) begin
                r_cnt[i] <= '0;
            end
        end else if (cnt_inc) begin
            r_cnt[cnt_idx] <= r_cnt[cnt_idx] + 1'b1;
        end else if (cnt_dec) begin
            r_cnt[cnt_idx] <= r_cnt[cnt_idx] - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fwe) begin
            r_fmem[fwaddr] <= fwdata;
        end
        r_fdata <= r_fmem[r_fidx[MI-1:FWB]];
    end

    always_ff @(posedge i_clk) begin
        if (awe) begin
            r_amem[awaddr] <= awdata;
        end
        r_adata <= r_amem[r_off];
    end

    assign o_cfg_ready = 1'b1;
    assign i_req.ready = (r_state == S_IDLE);
    assign o_rsp.valid = r_out_valid;
    assign o_rsp.block_offset = r_out_off;
    assign o_rsp.block_order = r_out_ord;
    assign o_rsp.status = r_out_st;

    // a scanned order always holds a free block
    a_scan_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCHK) |-> (r_cnt[r_k] != '0))
        else $error("scan of an empty order");

    a_split_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SPLIT) |-> (r_k >= r_ord))
        else $error("split went below requested order");

    a_merge_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MERGE) |-> (r_k <= TOP_K))
        else $error("merge climbed past top order");

    a_no_result_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_rsp.valid)
        else $error("result shown after reset");
endmodule
`default_nettype wire

/* dv/tb_top.sv */
// testbench for the buddy block allocator: directed and random traffic checked against a predictor
`default_nettype none
class alloc_scoreboard;
    localparam int TOPO = bba_pkg::ORDERS_DEF - 1;
    localparam int MAXU = 1 << TOPO;
    bit          free_mark[TOPO+1][];
    logic [4:0]  alloc_ord[];
    int unsigned pool;
    logic [bba_pkg::BOFF_W-1:0] exp_off[$];
    logic [bba_pkg::BORD_W-1:0] exp_ord[$];
    logic [bba_pkg::STAT_W-1:0] exp_st[$];
    int errors;

    function new();
        for (int k = 0; k <= TOPO; k++) free_mark[k] = new[MAXU >> k];
        alloc_ord = new[MAXU];
        pool = 32768;
        errors = 0;
    endfunction

    function void push(int unsigned o, int unsigned d, int unsigned s);
        exp_off.push_back(bba_pkg::BOFF_W'(o));
        exp_ord.push_back(bba_pkg::BORD_W'(d));
        exp_st.push_back(bba_pkg::STAT_W'(s));
    endfunction

    function void rebuild();
        int unsigned size, off;
        size = pool > MAXU ? MAXU : pool;
        off = 0;
        for (int k = 0; k <= TOPO; k++)
            for (int b = 0; b < (MAXU >> k); b++) free_mark[k][b] = 0;
        foreach (alloc_ord[i]) alloc_ord[i] = 0;
        for (int j = TOPO; j >= 0; j--)
            while (off + (1 << j) <= size) begin
                free_mark[j][off >> j] = 1;
                off += 1 << j;
            end
    endfunction

    // note an accepted request and queue its expected response
    function void note_request(logic [1:0] op, logic [15:0] req, logic [14:0] roff);
        int unsigned ord, k, off, cur;
        bit found;
        if (op == bba_pkg::OP_INIT) begin
            rebuild();
            push(0, 0, bba_pkg::STAT_OK);
        end else if (op == bba_pkg::OP_ALLOC) begin
            ord = 0;
            if (req == 0) req = 1;
            while (ord < 17 && (1 << ord) < req) ord++;
            if (ord > TOPO) begin
                push(0, 0, bba_pkg::STAT_TOO_LARGE);
                return;
            end
            found = 0;
            off = 0;
            for (k = ord; k <= TOPO && !found; k++)
                for (int b = 0; b < (MAXU >> k); b++)
                    if (free_mark[k][b]) begin
                        off = b << k; found = 1; break;
                    end
            if (!found) begin
                push(0, ord, bba_pkg::STAT_NO_FREE);
                return;
            end
            k--;
            free_mark[k][off >> k] = 0;
            while (k > ord) begin
                k--;
                free_mark[k][(off + (1 << k)) >> k] = 1;
            end
            alloc_ord[off] = 5'(ord + 1);
            push(off, ord, bba_pkg::STAT_OK);
        end else if (op == bba_pkg::OP_RELEASE) begin
            if (alloc_ord[roff] == 0) begin
                push(roff, 0, bba_pkg::STAT_NOT_ALLOC);
                return;
            end
            ord = alloc_ord[roff] - 1;
            alloc_ord[roff] = 0;
            k = ord;
            cur = roff;
            while (k < TOPO) begin
                if (!free_mark[k][(cur ^ (1 << k)) >> k]) break;
                free_mark[k][(cur ^ (1 << k)) >> k] = 0;
                cur &= ~(1 << k);
                k++;
            end
            free_mark[k][cur >> k] = 1;
            push(roff, ord, bba_pkg::STAT_OK);
        end
    endfunction

    task report(string what);
        $display("error at %0t: %s", $time, what);
        errors++;
    endtask

    task check_response(logic [14:0] off, logic [3:0] ord, logic [1:0] st);
        if (exp_st.size() == 0) begin
            report("response with nothing expected");
            return;
        end
        if (off !== exp_off[0])
            report($sformatf("block_offset %0d, want %0d", off, exp_off[0]));
        if (ord !== exp_ord[0])
            report($sformatf("block_order %0d, want %0d", ord, exp_ord[0]));
        if (st !== exp_st[0])
            report($sformatf("status %0d, want %0d", st, exp_st[0]));
        void'(exp_off.pop_front()); void'(exp_ord.pop_front()); void'(exp_st.pop_front());
    endtask
endclass

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [bba_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

    logic i_clk, i_rst_n, i_cfg_valid;
    logic [bba_pkg::POOL_W-1:0] i_cfg_data;
    wire o_cfg_ready;
    bba_req_if req_ch();
    bba_rsp_if rsp_ch();

    buddy_block_allocator_unit u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_valid(i_cfg_valid),
        .i_cfg_data(i_cfg_data), .o_cfg_ready(o_cfg_ready),
        .i_req(req_ch.sink), .o_rsp(rsp_ch.source)
    );

    alloc_scoreboard sb = new();
    int unsigned cycles = 0;
    bit hold_off = 0;
    int live_offs[$];   // offsets believed allocated, for well-formed releases
    localparam int unsigned LIMIT = 100_000_000;

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // response side: a drawn wait before each item, long hold-off when asked
    initial begin
        int w;
        rsp_ch.ready = 0;
        forever begin
            w = $urandom_range(0, 8);
            if (w != 0 || hold_off) begin
                rsp_ch.ready <= 0;
                repeat (w) @(posedge i_clk);
                while (hold_off) @(posedge i_clk);
            end
            rsp_ch.ready <= 1;
            do @(posedge i_clk); while (!rsp_ch.valid);
        end
    end

    always @(posedge i_clk)
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready)
            sb.check_response(rsp_ch.block_offset, rsp_ch.block_order, rsp_ch.status);

    task send(logic [1:0] op, logic [15:0] req, logic [14:0] roff);
        int gap;
        gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 8);
        if (gap != 0) begin
            req_ch.valid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid <= 1;
        req_ch.operation <= op;
        req_ch.request_units <= req;
        req_ch.release_offset <= roff;
        do @(posedge i_clk); while (!req_ch.ready);
        sb.note_request(op, req, roff);
    endtask

    task drain();
        req_ch.valid <= 0;
        while (sb.exp_st.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
    endtask

    task write_pool(logic [15:0] v);
        i_cfg_valid <= 1;
        i_cfg_data <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 0;
        sb.pool = v;
    endtask

    task alloc_one(logic [15:0] units);
        send(bba_pkg::OP_ALLOC, units, 15'($urandom_range(0, 32767)));
        if (sb.exp_st[$] == bba_pkg::STAT_OK) live_offs.push_back(sb.exp_off[$]);
    endtask

    task release_rand();
        int i;
        if (live_offs.size() != 0 && $urandom_range(0, 5) != 0) begin
            i = $urandom_range(0, live_offs.size() - 1);
            send(bba_pkg::OP_RELEASE, 16'($urandom), 15'(live_offs[i]));
            live_offs.delete(i);
        end else begin
            send(bba_pkg::OP_RELEASE, 16'($urandom), 15'($urandom_range(0, 32767)));
        end
    endtask

    function logic [15:0] rand_units();
        int r;
        r = $urandom_range(0, 15);
        if (r < 10) return 16'($urandom_range(0, 16));
        if (r < 14) return 16'($urandom_range(0, 512));
        return 16'($urandom_range(0, 65535));
    endfunction

    task init_pool();
        send(bba_pkg::OP_INIT, 16'($urandom), 15'($urandom));
        live_offs.delete();
    endtask

    initial begin
        logic [15:0] pools[6];
        pools = '{16'd1, 16'd100, 16'd32768, 16'd65535, 16'd0, 16'd1000};
        i_rst_n = 0;
        i_cfg_valid = 0;
        i_cfg_data = 0;
        req_ch.valid = 0;
        req_ch.operation = bba_pkg::OP_INIT;
        req_ch.request_units = 0;
        req_ch.release_offset = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1;

        // directed: before init, extremes, ignored op, split and merge
        alloc_one(1);
        send(bba_pkg::OP_RELEASE, 0, 15'h7fff);
        send(OP_UNUSED, 16'hffff, 15'h7fff);
        init_pool();
        alloc_one(0);
        alloc_one(16'd32768);
        alloc_one(16'd32769);
        alloc_one(16'hffff);
        send(bba_pkg::OP_RELEASE, 0, 0);
        send(bba_pkg::OP_RELEASE, 0, 0);
        alloc_one(3);
        alloc_one(1);
        send(bba_pkg::OP_RELEASE, 0, 5);
        send(bba_pkg::OP_RELEASE, 0, 15'h7fff);
        alloc_one(16'd16384);
        alloc_one(16'd16384);
        alloc_one(16'd1);
        init_pool();
        drain();

        // random phases over several pool sizes, with a long hold-off in the first
        foreach (pools[p]) begin
            write_pool(pools[p]);
            init_pool();
            if (p == 0) begin
                hold_off = 1;
                fork
                    begin repeat (400) @(posedge i_clk); hold_off = 0; end
                    repeat (6) alloc_one(1);
                join
            end
            for (int n = 0; n < 120; n++) begin
                case ($urandom_range(0, 19))
                    0: init_pool();
                    1: send(OP_UNUSED, 16'($urandom), 15'($urandom));
                    2, 3, 4, 5, 6, 7, 8: release_rand();
                    default: alloc_one(rand_units());
                endcase
            end
            drain();
        end
        if (sb.exp_st.size() != 0) sb.report("responses missing at end");
        if (sb.errors == 0) $display("No mismatches found");
        else $display("Mismatches found");
        $finish;
    end
endmodule
`default_nettype wire
